[rtl/rst_pkg.sv]
// ============================================================================
// Randomized set table package
// Field widths, operation and status codes, and the command and status
// groups passed between the controller and the datapath.
// ============================================================================
package rst_pkg;

    // Field widths of one request and one result.
    localparam int CMD_W      = 2;
    localparam int VALUE_W    = 32;
    localparam int DRAW_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int DRAW_CNT_W = $clog2(DRAW_W + 1);

    // Packed stream widths, padded to whole bytes.
    localparam int S_DATA_W = ((CMD_W + VALUE_W + DRAW_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((STATUS_W + VALUE_W + 7) / 8) * 8;

    // Operation codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PICK   = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load;        // capture a new request
        logic                scan_step;   // advance the member search
        logic                mod_step;    // one bit of draw modulo count
        logic                ins_write;   // append the value, grow the count
        logic                rd_last;     // read the last valid entry
        logic                move_write;  // move last entry into hit slot
        logic                rd_pick;     // read the entry at the remainder
        logic                out_load;    // load the result register
        logic [STATUS_W-1:0] out_status;  // status for the result
        logic                out_pick;    // result carries the read entry
    } rst_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             hit;        // search compare matched this cycle
        logic             scan_done;  // search ran past all valid entries
        logic             full;       // count equals capacity
        logic             empty;      // count is zero
        logic             mod_done;   // all draw bits consumed
        logic             out_free;   // result register can take a result
        logic [CMD_W-1:0] cmd;        // operation of the held request
    } rst_stat_t;

endpackage

[rtl/randomized_set_table_unit.sv]
// ============================================================================
// Randomized set table unit
// Set of distinct 32-bit values in a dense array with insert, remove and
// random pick operations.
// ============================================================================
// Requests arrive on the s_ stream channel and one result per request leaves
// on the m_ stream channel. A request is taken only while the unit is idle.
// Insert and remove search the member memory one entry per cycle through its
// single registered read port. A search that finds nothing ends once every
// valid entry has been compared, and an insert into a table that is not full
// then appends the value. A hit at position p ends the search early: a
// duplicate insert ends there, and a remove first moves the last entry into
// the freed slot. The longest request is a remove of the last entry of a full
// default table. A pick runs a restoring modulo of draw by the count, one
// draw bit per cycle; a pick on an empty table and an unused command go
// straight to the result. One request is in flight at a time, and the next
// one can be accepted in the cycle after its result is loaded.
// The result sits in an output register: the next request is accepted while
// it waits, and a new result waits in the controller until the held one is
// taken, so a stalled receiver stalls the unit only once a second result is
// ready. Reset empties the table at once; no memory clearing is needed, as
// only entries below the count are ever read.
// ============================================================================
module randomized_set_table_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // s_tdata: cmd [1:0], value [33:2], draw [49:34], zero [55:50]
    input  logic [rst_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // m_tdata: status [1:0], picked [33:2], zero [39:34]
    output logic [rst_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int CMD_LO   = 0;
    localparam int VALUE_LO = CMD_LO + rst_pkg::CMD_W;
    localparam int DRAW_LO  = VALUE_LO + rst_pkg::VALUE_W;
    localparam int M_USED_W = rst_pkg::STATUS_W + rst_pkg::VALUE_W;

    rst_pkg::rst_cmd_t            cmd;
    rst_pkg::rst_stat_t           stat;
    logic [rst_pkg::STATUS_W-1:0] out_status;
    logic [rst_pkg::VALUE_W-1:0]  out_picked;

    // Sequencer.
    rst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage, search, modulo and result register.
    rst_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_cmd     (s_tdata[CMD_LO +: rst_pkg::CMD_W]),
        .in_value   (s_tdata[VALUE_LO +: rst_pkg::VALUE_W]),
        .in_draw    (s_tdata[DRAW_LO +: rst_pkg::DRAW_W]),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_picked (out_picked)
    );

    // Result packing with zero fill.
    assign m_tdata = {{(rst_pkg::M_DATA_W - M_USED_W){1'b0}}, out_picked, out_status};

    // A full table never takes another entry.
    a_no_write_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.full |-> !cmd.ins_write)
        else $error("append issued on a full table");

    // An entry is moved only while the table holds something.
    a_no_move_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.move_write |-> !stat.empty)
        else $error("entry move issued on an empty table");

    // A held result is never overwritten before it is taken.
    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result register overwritten while stalled");

    // A picked member only comes with a done status.
    a_pick_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && cmd.out_pick) |-> (cmd.out_status == rst_pkg::STATUS_DONE))
        else $error("picked member with a failing status");

    // No search step and no result load come in the cycle after a load.
    a_search_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !cmd.scan_step && !cmd.out_load)
        else $error("request dispatched in the cycle it was loaded");

endmodule

[rtl/rst_datapath.sv]
// ============================================================================
// Randomized set table datapath
// Member memory, count, pipelined member search, restoring modulo unit and
// the result register.
// ============================================================================
module rst_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [rst_pkg::CMD_W-1:0]    in_cmd,
    input  logic [rst_pkg::VALUE_W-1:0]  in_value,
    input  logic [rst_pkg::DRAW_W-1:0]   in_draw,
    input  rst_pkg::rst_cmd_t            cmd,
    output rst_pkg::rst_stat_t           stat,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [rst_pkg::STATUS_W-1:0] out_status,
    output logic [rst_pkg::VALUE_W-1:0]  out_picked
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // Member storage.
    logic [rst_pkg::VALUE_W-1:0] mem [CAPACITY];

    // Request registers.
    logic [rst_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    logic [rst_pkg::VALUE_W-1:0] value_reg, value_next;
    logic [rst_pkg::DRAW_W-1:0]  draw_reg, draw_next;

    // Control registers.
    logic [CW-1:0]                  count_reg, count_next;
    logic [CW-1:0]                  scan_addr_reg, scan_addr_next;
    logic                           cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]                  cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0]                  pos_reg, pos_next;
    logic [CW-1:0]                  rem_reg, rem_next;
    logic [rst_pkg::DRAW_CNT_W-1:0] mod_left_reg, mod_left_next;
    logic                           out_valid_reg, out_valid_next;
    logic [rst_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [rst_pkg::VALUE_W-1:0]    out_picked_reg, out_picked_next;
    logic [rst_pkg::VALUE_W-1:0]    rd_data_reg;

    // Memory port signals.
    logic                        scan_issue;
    logic                        hit;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [rst_pkg::VALUE_W-1:0] wr_data;
    logic [CW-1:0]               count_minus;
    logic [CW:0]                 rem_shift;
    logic [CW:0]                 count_ext;

    assign count_minus = count_reg - CW'(1);
    assign scan_issue  = cmd.scan_step && (scan_addr_reg < count_reg);
    assign hit         = cmp_valid_reg && (rd_data_reg == value_reg);

    // Read port select: search address, last entry, or picked entry.
    always_comb begin
        rd_en   = scan_issue | cmd.rd_last | cmd.rd_pick;
        rd_addr = scan_addr_reg[AW-1:0];
        if (cmd.rd_last) begin
            rd_addr = count_minus[AW-1:0];
        end else if (cmd.rd_pick) begin
            rd_addr = rem_reg[AW-1:0];
        end
    end

    // Write port select: append at the count, or move into the hit slot.
    assign wr_en   = cmd.ins_write | cmd.move_write;
    assign wr_addr = cmd.move_write ? pos_reg : count_reg[AW-1:0];
    assign wr_data = cmd.move_write ? rd_data_reg : value_reg;

    // Memory with registered read data.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Restoring modulo: one draw bit per step, one compare and subtract.
    assign rem_shift = {rem_reg, draw_reg[rst_pkg::DRAW_W-1]};
    assign count_ext = {1'b0, count_reg};

    // Next-state logic of the datapath registers.
    always_comb begin
        cmd_next        = cmd_reg;
        value_next      = value_reg;
        draw_next       = draw_reg;
        count_next      = count_reg;
        scan_addr_next  = scan_addr_reg;
        cmp_valid_next  = scan_issue;
        cmp_idx_next    = cmp_idx_reg;
        pos_next        = pos_reg;
        rem_next        = rem_reg;
        mod_left_next   = mod_left_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_picked_next = out_picked_reg;

        if (cmd.load) begin
            cmd_next       = in_cmd;
            value_next     = in_value;
            draw_next      = in_draw;
            scan_addr_next = '0;
            rem_next       = '0;
            mod_left_next  = rst_pkg::DRAW_CNT_W'(rst_pkg::DRAW_W);
        end

        // Search: issue one read and compare the previous one each step.
        if (cmd.scan_step) begin
            if (scan_issue) begin
                scan_addr_next = scan_addr_reg + CW'(1);
                cmp_idx_next   = scan_addr_reg[AW-1:0];
            end
            if (hit) begin
                pos_next = cmp_idx_reg;
            end
        end

        if (cmd.mod_step) begin
            if (rem_shift >= count_ext) begin
                rem_next = CW'(rem_shift - count_ext);
            end else begin
                rem_next = rem_shift[CW-1:0];
            end
            draw_next     = draw_reg << 1;
            mod_left_next = mod_left_reg - rst_pkg::DRAW_CNT_W'(1);
        end

        if (cmd.ins_write) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.move_write) begin
            count_next = count_minus;
        end

        // Result register: load a new result or hand the held one over.
        if (cmd.out_load) begin
            out_valid_next  = 1'b1;
            out_status_next = cmd.out_status;
            out_picked_next = cmd.out_pick ? rd_data_reg : '0;
        end else if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            mod_left_reg  <= '0;
        end else begin
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
            mod_left_reg  <= mod_left_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        value_reg      <= value_next;
        draw_reg       <= draw_next;
        scan_addr_reg  <= scan_addr_next;
        cmp_idx_reg    <= cmp_idx_next;
        pos_reg        <= pos_next;
        rem_reg        <= rem_next;
        out_status_reg <= out_status_next;
        out_picked_reg <= out_picked_next;
    end

    // Status toward the controller.
    always_comb begin
        stat.hit       = hit;
        stat.scan_done = !cmp_valid_reg && (scan_addr_reg >= count_reg);
        stat.full      = (count_reg == CAP_C);
        stat.empty     = (count_reg == '0);
        stat.mod_done  = (mod_left_reg == '0);
        stat.out_free  = !out_valid_reg || out_ready;
        stat.cmd       = cmd_reg;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_picked = out_picked_reg;

endmodule

[rtl/rst_ctrl.sv]
// ============================================================================
// Randomized set table controller
// Sequences one request at a time through search, update, modulo and
// result hand-over.
// ============================================================================
module rst_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  rst_pkg::rst_stat_t stat,
    output rst_pkg::rst_cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_DISPATCH  = 9'b000000010,
        S_SCAN      = 9'b000000100,
        S_INSERT    = 9'b000001000,
        S_READ_LAST = 9'b000010000,
        S_MOVE      = 9'b000100000,
        S_MOD       = 9'b001000000,
        S_READ_PICK = 9'b010000000,
        S_FINISH    = 9'b100000000
    } ctrl_state_t;

    ctrl_state_t                  state_reg, state_next;
    logic [rst_pkg::STATUS_W-1:0] res_reg, res_next;
    logic                         pick_reg, pick_next;

    // State transitions and command decode.
    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        pick_next  = pick_reg;
        in_ready   = 1'b0;
        cmd        = '0;

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                res_next  = rst_pkg::STATUS_DONE;
                pick_next = 1'b0;
                case (stat.cmd)
                    rst_pkg::CMD_INSERT, rst_pkg::CMD_REMOVE: begin
                        state_next = S_SCAN;
                    end
                    rst_pkg::CMD_PICK: begin
                        if (stat.empty) begin
                            res_next   = rst_pkg::STATUS_EMPTY;
                            state_next = S_FINISH;
                        end else begin
                            state_next = S_MOD;
                        end
                    end
                    default: begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.hit) begin
                    if (stat.cmd == rst_pkg::CMD_INSERT) begin
                        res_next   = rst_pkg::STATUS_MISS;
                        state_next = S_FINISH;
                    end else begin
                        state_next = S_READ_LAST;
                    end
                end else if (stat.scan_done) begin
                    if (stat.cmd != rst_pkg::CMD_INSERT) begin
                        res_next   = rst_pkg::STATUS_MISS;
                        state_next = S_FINISH;
                    end else if (stat.full) begin
                        res_next   = rst_pkg::STATUS_FULL;
                        state_next = S_FINISH;
                    end else begin
                        state_next = S_INSERT;
                    end
                end
            end
            S_INSERT: begin
                cmd.ins_write = 1'b1;
                state_next    = S_FINISH;
            end
            S_READ_LAST: begin
                cmd.rd_last = 1'b1;
                state_next  = S_MOVE;
            end
            S_MOVE: begin
                cmd.move_write = 1'b1;
                state_next     = S_FINISH;
            end
            S_MOD: begin
                if (stat.mod_done) begin
                    state_next = S_READ_PICK;
                end else begin
                    cmd.mod_step = 1'b1;
                end
            end
            S_READ_PICK: begin
                cmd.rd_pick = 1'b1;
                pick_next   = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH: begin
                // Wait until the result register is free or being emptied.
                cmd.out_status = res_reg;
                cmd.out_pick   = pick_reg;
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            res_reg   <= rst_pkg::STATUS_DONE;
            pick_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
            pick_reg  <= pick_next;
        end
    end

endmodule

[tb/sv/tb_randomized_set_table_unit.sv]
// ============================================================================
// Randomized set table unit testbench
// Sends insert, remove and pick requests with random gaps and result stalls,
// keeps its own copy of the member table to work out each result, and checks
// every result in arrival order against that prediction.
// ============================================================================
module tb_randomized_set_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rst_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int POOL_SIZE    = 80;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 100;
    localparam int MAX_REPORTS  = 200;
    localparam int RANDOM_ITEMS = 600;
    localparam int PHASE_ITEMS  = 60;

    // Command code that the unit ignores.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  picked;
    } set_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // Predicted table contents and the results still to arrive.
    logic [VALUE_W-1:0] table_members [CAPACITY];
    int                 table_count = 0;
    set_result_t        expected_results [$];
    logic [VALUE_W-1:0] value_pool [POOL_SIZE];

    int fail_count    = 0;
    int idle_cycles   = 0;
    int rx_stall_left = 0;
    bit tx_no_gaps    = 1'b0;
    bit rx_no_stalls  = 1'b0;

    randomized_set_table_unit #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // 2 ns clock.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Position of a value among the valid entries, or -1 when absent.
    function automatic int member_index(input logic [VALUE_W-1:0] v);
        for (int i = 0; i < table_count; i++) begin
            if (table_members[i] == v) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one request to the predicted table and returns its result.
    function automatic set_result_t apply_request(input logic [CMD_W-1:0] op,
                                                  input logic [VALUE_W-1:0] v,
                                                  input logic [DRAW_W-1:0] drw);
        set_result_t r;
        int          pos;
        r.status = STATUS_DONE;
        r.picked = '0;
        pos = member_index(v);
        case (op)
            CMD_INSERT: begin
                // The duplicate check wins over the capacity check.
                if (pos >= 0) begin
                    r.status = STATUS_MISS;
                end else if (table_count >= CAPACITY) begin
                    r.status = STATUS_FULL;
                end else begin
                    table_members[table_count] = v;
                    table_count++;
                end
            end
            CMD_REMOVE: begin
                if (pos < 0) begin
                    r.status = STATUS_MISS;
                end else begin
                    table_members[pos] = table_members[table_count - 1];
                    table_count--;
                end
            end
            CMD_PICK: begin
                if (table_count == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    r.picked = table_members[int'(drw) % table_count];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Chooses new gap and stall behavior, sometimes with none at all.
    function automatic void pick_idle_modes();
        tx_no_gaps   = ($urandom_range(0, 3) == 0);
        rx_no_stalls = ($urandom_range(0, 3) == 0);
    endfunction

    // A value that is not in the table right now.
    function automatic logic [VALUE_W-1:0] fresh_value();
        logic [VALUE_W-1:0] v;
        do begin
            v = $urandom();
        end while (member_index(v) >= 0);
        return v;
    endfunction

    // Sends one request and records its predicted result once accepted.
    task automatic send_request(input logic [CMD_W-1:0] op,
                                input logic [VALUE_W-1:0] v,
                                input logic [DRAW_W-1:0] drw);
        logic [S_DATA_W-1:0] word;
        int                  gap;
        word = '0;
        word[CMD_W-1:0] = op;
        word[CMD_W +: VALUE_W] = v;
        word[CMD_W + VALUE_W +: DRAW_W] = drw;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 8);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        expected_results.push_back(apply_request(op, v, drw));
    endtask

    task automatic report_mismatch(input string field_name,
                                   input logic [VALUE_W-1:0] want,
                                   input logic [VALUE_W-1:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h",
                     $time, field_name, want, got);
        end
    endtask

    // Pick, remove and an unused command against an empty table.
    task automatic test_empty_table();
        send_request(CMD_PICK, 32'h0000_0000, 16'h0000);
        send_request(CMD_PICK, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(CMD_REMOVE, 32'h8000_0000, 16'h0000);
        send_request(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
    endtask

    // Extreme values, duplicates, removes at the start and at the end.
    task automatic test_insert_remove();
        send_request(CMD_INSERT, 32'h8000_0000, 16'h0000);
        send_request(CMD_INSERT, 32'h7FFF_FFFF, 16'hFFFF);
        send_request(CMD_INSERT, 32'h0000_0000, 16'h0000);
        send_request(CMD_INSERT, 32'hFFFF_FFFF, 16'h0000);
        send_request(CMD_INSERT, 32'h7FFF_FFFF, 16'h0000);
        send_request(CMD_PICK, 32'h0000_0000, 16'h0000);
        send_request(CMD_PICK, 32'h0000_0000, 16'hFFFF);
        // Removing the first entry moves the last one into its slot.
        send_request(CMD_REMOVE, 32'h8000_0000, 16'h0000);
        send_request(CMD_PICK, 32'h0000_0000, 16'h0000);
        // Zero now sits in the last slot.
        send_request(CMD_REMOVE, 32'h0000_0000, 16'h0000);
        send_request(CMD_REMOVE, 32'h0000_0000, 16'h0000);
        send_request(CMD_UNUSED, 32'h7FFF_FFFF, 16'h5555);
        send_request(CMD_PICK, 32'hFFFF_FFFF, 16'h5555);
        send_request(CMD_PICK, 32'h0000_0000, 16'hAAAA);
        send_request(CMD_REMOVE, 32'h7FFF_FFFF, 16'h0000);
        send_request(CMD_REMOVE, 32'hFFFF_FFFF, 16'h0000);
        send_request(CMD_PICK, 32'h0000_0000, 16'h0001);
    endtask

    // Fills the table, overflows it, and drains it again.
    task automatic test_full_table();
        pick_idle_modes();
        while (table_count < CAPACITY) begin
            send_request(CMD_INSERT, fresh_value(), 16'($urandom()));
        end
        send_request(CMD_INSERT, fresh_value(), 16'h0000);
        // A duplicate in a full table reports the duplicate.
        send_request(CMD_INSERT, table_members[$urandom_range(0, CAPACITY - 1)], 16'h0000);
        send_request(CMD_REMOVE, fresh_value(), 16'h0000);
        send_request(CMD_UNUSED, fresh_value(), 16'($urandom()));
        send_request(CMD_PICK, 32'h0000_0000, 16'h0000);
        send_request(CMD_PICK, 32'h0000_0000, 16'hFFFF);
        send_request(CMD_PICK, 32'h0000_0000, 16'($urandom()));
        pick_idle_modes();
        while (table_count > 0) begin
            if ($urandom_range(0, 3) == 0) begin
                send_request(CMD_PICK, 32'($urandom()), 16'($urandom()));
            end else begin
                send_request(CMD_REMOVE, table_members[$urandom_range(0, table_count - 1)],
                             16'($urandom()));
            end
        end
        send_request(CMD_PICK, 32'h0000_0000, 16'($urandom()));
    endtask

    // Mixed traffic in phases that lean toward filling or draining the table.
    task automatic test_random_traffic(input int count);
        int                 insert_share;
        int                 roll;
        int                 sel;
        logic [CMD_W-1:0]   op;
        logic [VALUE_W-1:0] v;
        logic [DRAW_W-1:0]  drw;
        insert_share = 40;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++) begin
            value_pool[i] = $urandom();
        end
        for (int n = 0; n < count; n++) begin
            if (n % PHASE_ITEMS == 0) begin
                pick_idle_modes();
                case ($urandom_range(0, 2))
                    0:       insert_share = 64;
                    1:       insert_share = 40;
                    default: insert_share = 16;
                endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                op = CMD_UNUSED;
            end else if (roll < 20) begin
                op = CMD_PICK;
            end else if (roll - 20 < insert_share) begin
                op = CMD_INSERT;
            end else begin
                op = CMD_REMOVE;
            end
            // Values come mostly from a small pool or the table itself so that
            // duplicates, hits and a full table all occur.
            sel = $urandom_range(0, 99);
            if (table_count > 0 && sel < (op == CMD_REMOVE ? 50 : 15)) begin
                v = table_members[$urandom_range(0, table_count - 1)];
            end else if (sel < 85) begin
                v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else begin
                v = $urandom();
            end
            case ($urandom_range(0, 9))
                0:       drw = 16'h0000;
                1:       drw = 16'hFFFF;
                default: drw = 16'($urandom());
            endcase
            send_request(op, v, drw);
        end
    endtask

    // Compares each result with the oldest prediction.
    always @(posedge aclk) begin
        set_result_t         want;
        logic [STATUS_W-1:0] got_status;
        logic [VALUE_W-1:0]  got_picked;
        if (aresetn && m_tvalid && m_tready) begin
            got_status = m_tdata[STATUS_W-1:0];
            got_picked = m_tdata[STATUS_W +: VALUE_W];
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected result, expected none, got status %0d picked 0x%08h",
                             $time, got_status, got_picked);
                end
            end else begin
                want = expected_results.pop_front();
                if (got_status !== want.status) begin
                    report_mismatch("status", VALUE_W'(want.status), VALUE_W'(got_status));
                end
                if (got_picked !== want.picked) begin
                    report_mismatch("picked", want.picked, got_picked);
                end
            end
            rx_stall_left = rx_no_stalls ? 0 : $urandom_range(0, 8);
        end
    end

    // Result side stalls for the drawn number of cycles after each result.
    always @(negedge aclk) begin
        if (rx_stall_left > 0) begin
            m_tready <= 1'b0;
            rx_stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Ends the run when nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Test sequence.
    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_table();
        test_insert_remove();
        test_full_table();
        test_random_traffic(RANDOM_ITEMS);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
